// ===== sv/himt_pkg.sv =====
package himt_pkg;

  // Input word layout, lowest bit first
  localparam int IN_TDATA_W  = 152;
  localparam int FUNC_W      = 3;
  localparam int IDX_W       = 8;
  localparam int HDL_W       = 64;
  localparam int FUNC_LSB    = 0;
  localparam int PIDX_LSB    = 3;
  localparam int DIDX_LSB    = 11;
  localparam int PHDL_LSB    = 19;
  localparam int DHDL_LSB    = 83;

  // Result word layout, lowest bit first
  localparam int OUT_TDATA_W = 80;
  localparam int STATUS_W    = 2;
  localparam int STATUS_LSB  = 0;
  localparam int HOUT_LSB    = 2;
  localparam int IOUT_LSB    = 66;

  localparam logic [FUNC_W-1:0] FN_INSERT   = 3'd0;
  localparam logic [FUNC_W-1:0] FN_REMOVE   = 3'd1;
  localparam logic [FUNC_W-1:0] FN_GET_PHDL = 3'd2;
  localparam logic [FUNC_W-1:0] FN_GET_DHDL = 3'd3;
  localparam logic [FUNC_W-1:0] FN_GET_PIDX = 3'd4;
  localparam logic [FUNC_W-1:0] FN_GET_DIDX = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_INSERT = 5'b00010,
    S_SCAN   = 5'b00100,
    S_SHIFT  = 5'b01000,
    S_DONE   = 5'b10000
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic shift_start;
    logic shift;
    logic insert;
    logic dec_count;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic hit;
    logic scan_end;
    logic is_remove;
    logic out_free;
  } ctrl_sts_t;

endpackage

// ===== sv/himt_ram.sv =====
module himt_ram #(
  parameter int WIDTH = 144,
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/himt_ctrl.sv =====
module himt_ctrl
  import himt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic [FUNC_W-1:0] in_func,
  output logic              in_tready,
  output ctrl_cmd_t         cmd,
  input  ctrl_sts_t         sts
);

  ctrl_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load = 1'b1;
          case (in_func)
            FN_INSERT: begin
              state_nxt = S_INSERT;
            end
            FN_REMOVE, FN_GET_PHDL, FN_GET_DHDL, FN_GET_PIDX, FN_GET_DIDX: begin
              state_nxt = S_SCAN;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_INSERT: begin
        cmd.insert = 1'b1;
        state_nxt  = S_DONE;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.hit) begin
          if (sts.is_remove) begin
            cmd.shift_start = 1'b1;
            state_nxt       = S_SHIFT;
          end else begin
            state_nxt = S_DONE;
          end
        end else if (sts.scan_end) begin
          state_nxt = S_DONE;
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (sts.scan_end) begin
          cmd.dec_count = 1'b1;
          state_nxt     = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_lookup_hit_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && sts.hit && !sts.is_remove) |=> (state_r == S_DONE))
    else $error("lookup hit did not finish");
  a_remove_hit_shift: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && sts.hit && sts.is_remove) |=> (state_r == S_SHIFT))
    else $error("remove hit did not start compaction");
`endif

endmodule

// ===== sv/himt_dp.sv =====
module himt_dp
  import himt_pkg::*;
#(
  parameter int TABLE_DEPTH = 32,
  parameter int HANDLE_BITS = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  ctrl_cmd_t              cmd,
  output ctrl_sts_t              sts,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = 2 * IDX_W + 2 * HANDLE_BITS;

  // Request held for the whole operation
  logic [FUNC_W-1:0]      func_r, func_nxt;
  logic [IDX_W-1:0]       pidx_r, pidx_nxt;
  logic [IDX_W-1:0]       didx_r, didx_nxt;
  logic [HANDLE_BITS-1:0] phdl_r, phdl_nxt;
  logic [HANDLE_BITS-1:0] dhdl_r, dhdl_nxt;

  logic [CW-1:0]          count_r, count_nxt;
  logic [CW-1:0]          ptr_r, ptr_nxt;
  logic                   dv_r, dv_nxt;
  logic [AW-1:0]          idx_r, idx_nxt;

  logic [STATUS_W-1:0]    res_status_r, res_status_nxt;
  logic [HDL_W-1:0]       res_hdl_r, res_hdl_nxt;
  logic [IDX_W-1:0]       res_idx_r, res_idx_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [EW-1:0]          ram_wdata;
  logic [EW-1:0]          ram_rdata;

  logic [IDX_W-1:0]       e_pidx, e_didx;
  logic [HANDLE_BITS-1:0] e_phdl, e_dhdl;
  logic                   match, hit, scan_end, full;

  himt_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ptr_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign e_pidx = ram_rdata[0 +: IDX_W];
  assign e_didx = ram_rdata[IDX_W +: IDX_W];
  assign e_phdl = ram_rdata[2 * IDX_W +: HANDLE_BITS];
  assign e_dhdl = ram_rdata[2 * IDX_W + HANDLE_BITS +: HANDLE_BITS];

  always_comb begin
    case (func_r)
      FN_REMOVE, FN_GET_DIDX: match = (e_phdl == phdl_r) && (e_dhdl == dhdl_r);
      FN_GET_PHDL:            match = (e_pidx == pidx_r);
      FN_GET_DHDL:            match = (e_pidx == pidx_r) && (e_didx == didx_r);
      FN_GET_PIDX:            match = (e_phdl == phdl_r);
      default:                match = 1'b0;
    endcase
  end

  assign hit      = dv_r && match;
  assign scan_end = !dv_r && (ptr_r >= count_r);
  assign full     = (count_r >= CW'(TABLE_DEPTH));

  assign sts.hit       = hit;
  assign sts.scan_end  = scan_end;
  assign sts.is_remove = (func_r == FN_REMOVE);
  assign sts.out_free  = !out_valid_r || out_tready;

  // Compaction writes each fetched entry one place down
  assign ram_we    = (cmd.insert && !full) || (cmd.shift && dv_r);
  assign ram_waddr = cmd.insert ? count_r[AW-1:0] : (idx_r - AW'(1));
  assign ram_wdata = cmd.insert ? {dhdl_r, phdl_r, didx_r, pidx_r} : ram_rdata;

  always_comb begin
    func_nxt       = func_r;
    pidx_nxt       = pidx_r;
    didx_nxt       = didx_r;
    phdl_nxt       = phdl_r;
    dhdl_nxt       = dhdl_r;
    count_nxt      = count_r;
    ptr_nxt        = ptr_r;
    dv_nxt         = dv_r;
    idx_nxt        = idx_r;
    res_status_nxt = res_status_r;
    res_hdl_nxt    = res_hdl_r;
    res_idx_nxt    = res_idx_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r;

    if (cmd.load) begin
      func_nxt       = in_tdata[FUNC_LSB +: FUNC_W];
      pidx_nxt       = in_tdata[PIDX_LSB +: IDX_W];
      didx_nxt       = in_tdata[DIDX_LSB +: IDX_W];
      phdl_nxt       = in_tdata[PHDL_LSB +: HANDLE_BITS];
      dhdl_nxt       = in_tdata[DHDL_LSB +: HANDLE_BITS];
      ptr_nxt        = '0;
      dv_nxt         = 1'b0;
      res_status_nxt = ST_MISS;
      res_hdl_nxt    = '0;
      res_idx_nxt    = '0;
    end

    // Fetch one entry a cycle; compare it the cycle after
    if (cmd.scan || cmd.shift) begin
      dv_nxt  = (ptr_r < count_r);
      idx_nxt = ptr_r[AW-1:0];
      if (ptr_r < count_r) begin
        ptr_nxt = ptr_r + CW'(1);
      end
    end

    if (cmd.scan && hit) begin
      res_status_nxt = ST_OK;
      case (func_r)
        FN_GET_PHDL: res_hdl_nxt = HDL_W'(e_phdl);
        FN_GET_DHDL: res_hdl_nxt = HDL_W'(e_dhdl);
        FN_GET_PIDX: res_idx_nxt = e_pidx;
        FN_GET_DIDX: res_idx_nxt = e_didx;
        default: ;
      endcase
    end

    if (cmd.shift_start) begin
      ptr_nxt = CW'(idx_r) + CW'(1);
      dv_nxt  = 1'b0;
    end

    if (cmd.insert) begin
      if (full) begin
        res_status_nxt = ST_FULL;
      end else begin
        res_status_nxt = ST_OK;
        count_nxt      = count_r + CW'(1);
      end
    end

    if (cmd.dec_count) begin
      count_nxt      = count_r - CW'(1);
      res_status_nxt = ST_OK;
    end

    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {{(OUT_TDATA_W - IOUT_LSB - IDX_W){1'b0}},
                       res_idx_r, res_hdl_r, res_status_r};
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ptr_r       <= '0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      ptr_r       <= ptr_nxt;
      dv_r        <= dv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    pidx_r       <= pidx_nxt;
    didx_r       <= didx_nxt;
    phdl_r       <= phdl_nxt;
    dhdl_r       <= dhdl_nxt;
    idx_r        <= idx_nxt;
    res_status_r <= res_status_nxt;
    res_hdl_r    <= res_hdl_nxt;
    res_idx_r    <= res_idx_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");
  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.insert && !full) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("insert did not add an entry");
  a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.dec_count |=> (count_r == $past(count_r) - CW'(1)))
    else $error("remove did not drop an entry");
  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> (out_tvalid && out_tdata[STATUS_LSB +: STATUS_W] == $past(res_status_r)))
    else $error("result word not presented");
`endif

endmodule

// ===== sv/handle_index_map_table_core.sv =====
// Insert: S_INSERT writes the entry, then S_DONE registers the result word once the output is free.
// Lookup and remove walk the stored entries through the single read port of
// the table RAM, one entry fetched per cycle.
// One request in flight; the next word is taken the cycle after a result is
// loaded, while that result may still wait in the output register.
// Synchronous active-low reset empties the table; RAM contents are kept.
module handle_index_map_table_core
  import himt_pkg::*;
#(
  parameter int TABLE_DEPTH = 32,
  parameter int HANDLE_BITS = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // func[2:0], participant_idx[10:3], domain_idx[18:11],
  // participant_hdl[82:19], domain_hdl[146:83], zero pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // status[1:0], handle_out[65:2], index_out[73:66], zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  himt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_func   (in_tdata[FUNC_LSB +: FUNC_W]),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  himt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
